// ===== hdl/i2d_pkg.sv =====
// ----------------------------------------------------------------------------
// i2d_pkg
// Shared types and constants for the 64-bit integer to decimal ASCII block.
// ----------------------------------------------------------------------------
package i2d_pkg;

   localparam int NUM_BITS   = 64;                    // input word width
   localparam int NUM_DIGITS = 20;                    // decimal digits of 2^64-1
   localparam int BCD_W      = 4 * NUM_DIGITS;
   localparam int ITER_W     = $clog2(NUM_BITS);
   localparam int LEN_W      = 5;                     // up to 20 characters
   localparam int BUF_W      = 8;
   localparam int CHAR_W     = 8;
   localparam int QDEPTH     = 2;                     // front-to-back queue entries

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;  // '0'
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;  // '9'
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;  // '-'

   localparam logic FUNC_SIGNED   = 1'b0;
   localparam logic FUNC_UNSIGNED = 1'b1;

   // classified request handed from front to back
   typedef struct packed {
      logic                neg;
      logic [NUM_BITS-1:0] mag;
      logic [BUF_W-1:0]    buf_size;
   } job_type;

endpackage

// ===== hdl/i2d_front.sv =====
// ----------------------------------------------------------------------------
// i2d_front
// Accepts requests, forms sign and magnitude, and queues them for the back end.
// ----------------------------------------------------------------------------
module i2d_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_func,
   input  logic [i2d_pkg::NUM_BITS-1:0]  req_number,
   input  logic [i2d_pkg::BUF_W-1:0]     req_buffer_size,
   output logic                          job_valid,
   output i2d_pkg::job_type              job,
   input  logic                          job_pop
);
   import i2d_pkg::*;

   localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   job_type             q_mem [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                push;
   job_type             entry;

   always_comb begin
      entry.neg      = (req_func == FUNC_SIGNED) && req_number[NUM_BITS-1];
      entry.mag      = entry.neg ? (~req_number + 1'b1) : req_number;
      entry.buf_size = req_buffer_size;
   end

   assign busy      = (count_ff == QCNT_W'(QDEPTH));
   assign push      = start && !busy;
   assign job_valid = (count_ff != '0);
   assign job       = q_mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (job_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !job_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && job_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem[wr_ptr_ff] <= entry;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QDEPTH))
      else $error("queue count overflow");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      job_pop |-> job_valid)
      else $error("pop from empty queue");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      push && !job_pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count did not follow push");

endmodule

// ===== hdl/i2d_back.sv =====
// ----------------------------------------------------------------------------
// i2d_back
// Double-dabble binary to BCD, leading zero strip, fit check, character emit.
// ----------------------------------------------------------------------------
module i2d_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          job_valid,
   input  i2d_pkg::job_type              job,
   output logic                          job_pop,
   output logic                          rsp_strobe,
   output logic [i2d_pkg::CHAR_W-1:0]    rsp_character,
   output logic                          rsp_last,
   output logic                          rsp_ok,
   output logic [i2d_pkg::LEN_W-1:0]     rsp_length
);
   import i2d_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CONV  = 3'd1;
   localparam logic [2:0] ST_NORM  = 3'd2;
   localparam logic [2:0] ST_CHECK = 3'd3;
   localparam logic [2:0] ST_EMIT  = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic [NUM_BITS-1:0] mag_ff, mag_in;
   logic [BCD_W-1:0]    bcd_ff, bcd_in;
   logic [ITER_W-1:0]   iter_ff, iter_in;
   logic [LEN_W-1:0]    ndig_ff, ndig_in;
   logic [LEN_W-1:0]    remain_ff, remain_in;
   logic                neg_ff, neg_in;
   logic                sign_pend_ff, sign_pend_in;
   logic [BUF_W-1:0]    bufsz_ff, bufsz_in;

   logic                rsp_strobe_ff, rsp_strobe_in;
   logic [CHAR_W-1:0]   rsp_character_ff, rsp_character_in;
   logic                rsp_last_ff, rsp_last_in;
   logic                rsp_ok_ff, rsp_ok_in;
   logic [LEN_W-1:0]    rsp_length_ff, rsp_length_in;

   logic [BCD_W-1:0]    bcd_adj;
   logic [LEN_W-1:0]    total;
   logic [3:0]          top_digit;

   // add 3 to every digit of 5 or more before the shift
   always_comb begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
         bcd_adj[4*d +: 4] = (bcd_ff[4*d +: 4] >= 4'd5) ? bcd_ff[4*d +: 4] + 4'd3
                                                         : bcd_ff[4*d +: 4];
      end
   end

   assign total     = ndig_ff + LEN_W'(neg_ff);
   assign top_digit = bcd_ff[BCD_W-1 -: 4];
   assign job_pop   = (state_ff == ST_IDLE) && job_valid;

   always_comb begin
      state_in         = state_ff;
      mag_in           = mag_ff;
      bcd_in           = bcd_ff;
      iter_in          = iter_ff;
      ndig_in          = ndig_ff;
      remain_in        = remain_ff;
      neg_in           = neg_ff;
      sign_pend_in     = sign_pend_ff;
      bufsz_in         = bufsz_ff;
      rsp_strobe_in    = 1'b0;
      rsp_character_in = rsp_character_ff;
      rsp_last_in      = rsp_last_ff;
      rsp_ok_in        = rsp_ok_ff;
      rsp_length_in    = rsp_length_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               mag_in   = job.mag;
               neg_in   = job.neg;
               bufsz_in = job.buf_size;
               bcd_in   = '0;
               iter_in  = '0;
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            bcd_in  = {bcd_adj[BCD_W-2:0], mag_ff[NUM_BITS-1]};
            mag_in  = {mag_ff[NUM_BITS-2:0], 1'b0};
            iter_in = iter_ff + 1'b1;
            if (iter_ff == ITER_W'(NUM_BITS - 1)) begin
               ndig_in  = LEN_W'(NUM_DIGITS);
               state_in = ST_NORM;
            end
         end
         ST_NORM: begin
            // strip leading zeros, keeping at least one digit
            if (top_digit == 4'd0 && ndig_ff > LEN_W'(1)) begin
               bcd_in  = {bcd_ff[BCD_W-5:0], 4'd0};
               ndig_in = ndig_ff - 1'b1;
            end else begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if ({{(BUF_W-LEN_W){1'b0}}, total} >= bufsz_ff) begin
               rsp_strobe_in    = 1'b1;
               rsp_character_in = '0;
               rsp_last_in      = 1'b1;
               rsp_ok_in        = 1'b0;
               rsp_length_in    = '0;
               state_in         = ST_IDLE;
            end else begin
               remain_in     = total;
               sign_pend_in  = neg_ff;
               rsp_length_in = total;
               state_in      = ST_EMIT;
            end
         end
         ST_EMIT: begin
            rsp_strobe_in = 1'b1;
            rsp_ok_in     = 1'b1;
            rsp_last_in   = (remain_ff == LEN_W'(1));
            if (sign_pend_ff) begin
               rsp_character_in = CHAR_MINUS;
               sign_pend_in     = 1'b0;
            end else begin
               rsp_character_in = CHAR_ZERO + {4'd0, top_digit};
               bcd_in           = {bcd_ff[BCD_W-5:0], 4'd0};
            end
            remain_in = remain_ff - 1'b1;
            if (remain_ff == LEN_W'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff           <= mag_in;
      bcd_ff           <= bcd_in;
      iter_ff          <= iter_in;
      ndig_ff          <= ndig_in;
      remain_ff        <= remain_in;
      neg_ff           <= neg_in;
      sign_pend_ff     <= sign_pend_in;
      bufsz_ff         <= bufsz_in;
      rsp_character_ff <= rsp_character_in;
      rsp_last_ff      <= rsp_last_in;
      rsp_ok_ff        <= rsp_ok_in;
      rsp_length_ff    <= rsp_length_in;
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_character = rsp_character_ff;
   assign rsp_last      = rsp_last_ff;
   assign rsp_ok        = rsp_ok_ff;
   assign rsp_length    = rsp_length_ff;

   a_fail_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && !rsp_ok_ff |-> rsp_last_ff && rsp_length_ff == '0
                                      && rsp_character_ff == '0)
      else $error("malformed reject");

   a_char_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && rsp_ok_ff |-> rsp_length_ff != '0 &&
         (rsp_character_ff == CHAR_MINUS ||
          (rsp_character_ff >= CHAR_ZERO && rsp_character_ff <= CHAR_NINE)))
      else $error("bad character");

   a_run_cont: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && !rsp_last_ff |=> rsp_strobe_ff && rsp_ok_ff &&
         rsp_length_ff == $past(rsp_length_ff))
      else $error("character run broken");

   a_run_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && rsp_last_ff |=> !rsp_strobe_ff)
      else $error("strobe after last character");

endmodule

// ===== hdl/int64_to_decimal_ascii_top.sv =====
// ----------------------------------------------------------------------------
// int64_to_decimal_ascii_top
// 64-bit signed/unsigned integer to decimal ASCII character stream.
// ----------------------------------------------------------------------------
// Request channel: drive req_func (0 signed, 1 unsigned), req_number and
// req_buffer_size with start high; the request is taken on an edge where
// busy is low. A two-entry queue sits between the front end and the
// converter, so up to two requests can wait while one is converted.
// Response channel: one character per rsp_strobe cycle, most significant
// first, with a leading '-' for negative signed values. rsp_length holds
// the full count on every character; rsp_last marks the final one. If the
// text plus a terminator does not fit req_buffer_size, a single response
// with rsp_ok low, rsp_length zero and rsp_last high is given instead.
// Steps per request, once it reaches the converter: a load, one double-dabble
// shift per input bit, the leading zero strip, the fit check, then one
// character per cycle. The total does not depend on the digit count, but a
// minus sign lengthens it; a reject ends at the fit check. The shift loop
// dominates. The receiver cannot stall; every strobe is a delivered
// character. Synchronous reset empties the queue and aborts any
// conversion in flight; no strobe follows reset.
// ----------------------------------------------------------------------------
module int64_to_decimal_ascii_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_func,
   input  logic [i2d_pkg::NUM_BITS-1:0]  req_number,
   input  logic [i2d_pkg::BUF_W-1:0]     req_buffer_size,
   output logic                          rsp_strobe,
   output logic [i2d_pkg::CHAR_W-1:0]    rsp_character,
   output logic                          rsp_last,
   output logic                          rsp_ok,
   output logic [i2d_pkg::LEN_W-1:0]     rsp_length
);
   import i2d_pkg::*;

   logic    job_valid;
   logic    job_pop;
   job_type job;

   i2d_front u_front (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_func        (req_func),
      .req_number      (req_number),
      .req_buffer_size (req_buffer_size),
      .job_valid       (job_valid),
      .job             (job),
      .job_pop         (job_pop)
   );

   i2d_back u_back (
      .clock         (clock),
      .reset         (reset),
      .job_valid     (job_valid),
      .job           (job),
      .job_pop       (job_pop),
      .rsp_strobe    (rsp_strobe),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last),
      .rsp_ok        (rsp_ok),
      .rsp_length    (rsp_length)
   );

endmodule

// ===== tb/i2d_checker.sv =====
// ----------------------------------------------------------------------------
// i2d_checker
// Watches the request and response channels of the integer to decimal ASCII
// block. Each accepted request is converted here into the characters it
// should produce; each response strobe is compared with the oldest character
// still owed. Mismatches are counted and handed to the testbench top.
// ----------------------------------------------------------------------------
module i2d_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic                         busy,
   input  logic                         req_func,
   input  logic [i2d_pkg::NUM_BITS-1:0] req_number,
   input  logic [i2d_pkg::BUF_W-1:0]    req_buffer_size,
   input  logic                         rsp_strobe,
   input  logic [i2d_pkg::CHAR_W-1:0]   rsp_character,
   input  logic                         rsp_last,
   input  logic                         rsp_ok,
   input  logic [i2d_pkg::LEN_W-1:0]    rsp_length,
   input  logic                         run_over,
   output int                           outstanding,
   output int                           mismatch_count
);
   import i2d_pkg::*;

   typedef struct packed {
      logic [CHAR_W-1:0] character;
      logic              last;
      logic              ok;
      logic [LEN_W-1:0]  length;
   } text_char_type;

   text_char_type owed_chars[$];
   text_char_type want;
   bit            leftovers_flushed = 1'b0;

   task automatic report_mismatch(input string what);
      $display("[%0t] MISMATCH: %s", $time, what);
      mismatch_count++;
   endtask

   // Decimal text of one request, sign first, or the single reject beat.
   function automatic void convert_to_text(input logic                func,
                                           input logic [NUM_BITS-1:0] number,
                                           input logic [BUF_W-1:0]    buf_size);
      logic              negative;
      logic [NUM_BITS-1:0] mag;
      logic [CHAR_W-1:0] digits [NUM_DIGITS];
      int                ndig;
      int                total;
      int                k;
      text_char_type     c;

      negative = (func == FUNC_SIGNED) && number[NUM_BITS-1];
      mag      = negative ? (~number + 64'd1) : number;
      ndig     = 0;
      do begin
         digits[ndig] = CHAR_ZERO + CHAR_W'(mag % 64'd10);
         ndig++;
         mag = mag / 64'd10;
      end while (mag != 0 && ndig < NUM_DIGITS);
      total = ndig + (negative ? 1 : 0);

      // text plus terminator must fit the buffer
      if (total >= int'(buf_size)) begin
         c.character = '0;
         c.last      = 1'b1;
         c.ok        = 1'b0;
         c.length    = '0;
         owed_chars.push_back(c);
         return;
      end

      for (k = 0; k < total; k++) begin
         if (negative && k == 0)
            c.character = CHAR_MINUS;
         else
            c.character = digits[ndig - 1 - (k - (negative ? 1 : 0))];
         c.last   = (k == total - 1);
         c.ok     = 1'b1;
         c.length = LEN_W'(total);
         owed_chars.push_back(c);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         owed_chars.delete();
      end else begin
         if (start && !busy)
            convert_to_text(req_func, req_number, req_buffer_size);

         if (rsp_strobe) begin
            if (owed_chars.size() == 0) begin
               report_mismatch($sformatf("unexpected response char=0x%02h ok=%0b",
                                         rsp_character, rsp_ok));
            end else begin
               want = owed_chars.pop_front();
               if (rsp_character !== want.character)
                  report_mismatch($sformatf("character 0x%02h, expected 0x%02h",
                                            rsp_character, want.character));
               if (rsp_last !== want.last)
                  report_mismatch($sformatf("last %0b, expected %0b",
                                            rsp_last, want.last));
               if (rsp_ok !== want.ok)
                  report_mismatch($sformatf("ok %0b, expected %0b", rsp_ok, want.ok));
               if (rsp_length !== want.length)
                  report_mismatch($sformatf("length %0d, expected %0d",
                                            rsp_length, want.length));
            end
         end

         if (run_over && !leftovers_flushed) begin
            leftovers_flushed = 1'b1;
            while (owed_chars.size() != 0) begin
               want = owed_chars.pop_front();
               report_mismatch($sformatf("missing response char=0x%02h ok=%0b",
                                         want.character, want.ok));
            end
         end
      end
      outstanding = owed_chars.size();
   end

endmodule

// ===== tb/tb_int64_to_decimal_ascii_top.sv =====
// ----------------------------------------------------------------------------
// tb_int64_to_decimal_ascii_top
// Drives the integer to decimal ASCII block with directed corner cases
// (zero, extremes of both modes, buffer fit boundaries) and then random
// requests with random sender gaps. A checker beside the block predicts and
// compares every character; this module reports the verdict.
// ----------------------------------------------------------------------------
module tb_int64_to_decimal_ascii_top;
   import i2d_pkg::*;

   localparam int RANDOM_REQUESTS = 358;
   localparam int CALM_TAIL       = 60;    // final requests sent back to back
   localparam int SETTLE_CYCLES   = 120;

   logic                clock           = 1'b0;
   logic                reset           = 1'b1;
   logic                start           = 1'b0;
   logic                busy;
   logic                req_func        = FUNC_SIGNED;
   logic [NUM_BITS-1:0] req_number      = '0;
   logic [BUF_W-1:0]    req_buffer_size = '0;
   logic                rsp_strobe;
   logic [CHAR_W-1:0]   rsp_character;
   logic                rsp_last;
   logic                rsp_ok;
   logic [LEN_W-1:0]    rsp_length;
   logic                run_over        = 1'b0;
   int                  outstanding;
   int                  mismatch_count;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   int64_to_decimal_ascii_top i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_func        (req_func),
      .req_number      (req_number),
      .req_buffer_size (req_buffer_size),
      .rsp_strobe      (rsp_strobe),
      .rsp_character   (rsp_character),
      .rsp_last        (rsp_last),
      .rsp_ok          (rsp_ok),
      .rsp_length      (rsp_length)
   );

   i2d_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_func        (req_func),
      .req_number      (req_number),
      .req_buffer_size (req_buffer_size),
      .rsp_strobe      (rsp_strobe),
      .rsp_character   (rsp_character),
      .rsp_last        (rsp_last),
      .rsp_ok          (rsp_ok),
      .rsp_length      (rsp_length),
      .run_over        (run_over),
      .outstanding     (outstanding),
      .mismatch_count  (mismatch_count)
   );

   // Returns at the edge where the request was taken; start stays high.
   task automatic send_request(input logic                func,
                               input logic [NUM_BITS-1:0] number,
                               input logic [BUF_W-1:0]    buf_size);
      start           <= 1'b1;
      req_func        <= func;
      req_number      <= number;
      req_buffer_size <= buf_size;
      do @(posedge clock); while (busy);
   endtask

   task automatic sender_gap(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic wait_for_drain();
      start <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      @(posedge clock);
   endtask

   function automatic logic [NUM_BITS-1:0] random_number();
      logic [NUM_BITS-1:0] full;
      logic [NUM_BITS-1:0] pow10;
      int                  k;

      full = {$urandom, $urandom};
      case ($urandom_range(0, 4))
         0: return full;
         1: return full >> $urandom_range(0, 63);
         2: begin
            // powers of ten and their neighbors move the digit count
            pow10 = 64'd1;
            for (k = $urandom_range(0, 19); k > 0; k--)
               pow10 = pow10 * 64'd10;
            return pow10 + 64'($urandom_range(0, 2)) - 64'd1;
         end
         3: return ~(full >> $urandom_range(1, 63)) + 64'd1;
         default: begin
            case ($urandom_range(0, 3))
               0:       return 64'h0;
               1:       return 64'hFFFF_FFFF_FFFF_FFFF;
               2:       return 64'h8000_0000_0000_0000;
               default: return 64'h7FFF_FFFF_FFFF_FFFF;
            endcase
         end
      endcase
   endfunction

   function automatic logic [BUF_W-1:0] random_buffer_size();
      case ($urandom_range(0, 3))
         0, 1:    return BUF_W'($urandom_range(0, 24));
         2:       return BUF_W'($urandom_range(0, 255));
         default: return 8'd255;
      endcase
   endfunction

   initial begin
      int i;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero and tiny buffers
      send_request(FUNC_UNSIGNED, 64'd0, 8'd2);
      send_request(FUNC_SIGNED,   64'd0, 8'd1);
      send_request(FUNC_SIGNED,   64'd0, 8'd0);
      // twenty characters: exact fit and one short
      send_request(FUNC_UNSIGNED, 64'hFFFF_FFFF_FFFF_FFFF, 8'd21);
      send_request(FUNC_UNSIGNED, 64'hFFFF_FFFF_FFFF_FFFF, 8'd20);
      send_request(FUNC_SIGNED,   64'h8000_0000_0000_0000, 8'd21);
      send_request(FUNC_SIGNED,   64'h8000_0000_0000_0000, 8'd20);
      send_request(FUNC_SIGNED,   64'h7FFF_FFFF_FFFF_FFFF, 8'd20);
      send_request(FUNC_UNSIGNED, 64'h8000_0000_0000_0000, 8'd255);
      // minus one in both modes
      send_request(FUNC_SIGNED,   64'hFFFF_FFFF_FFFF_FFFF, 8'd3);
      send_request(FUNC_SIGNED,   64'hFFFF_FFFF_FFFF_FFFF, 8'd2);
      send_request(FUNC_UNSIGNED, 64'hFFFF_FFFF_FFFF_FFFF, 8'd255);
      // digit count boundaries
      send_request(FUNC_UNSIGNED, 64'd9, 8'd2);
      send_request(FUNC_UNSIGNED, 64'd10, 8'd2);
      send_request(FUNC_SIGNED,   64'd10, 8'd3);
      send_request(FUNC_UNSIGNED, 64'd1_000_000_000_000, 8'd14);
      send_request(FUNC_UNSIGNED, 64'd999_999_999_999, 8'd13);
      send_request(FUNC_SIGNED,   ~64'd1_000_000_000_000 + 64'd1, 8'd15);
      send_request(FUNC_SIGNED,   ~64'd100 + 64'd1, 8'd255);
      send_request(FUNC_UNSIGNED, 64'd10_000_000_000_000_000_000, 8'd21);
      send_request(FUNC_SIGNED,   64'd123_456_789, 8'd128);
      send_request(FUNC_UNSIGNED, 64'd5, 8'd255);

      for (i = 0; i < RANDOM_REQUESTS; i++) begin
         send_request(logic'($urandom_range(0, 1)), random_number(), random_buffer_size());
         if (i == RANDOM_REQUESTS / 3)
            wait_for_drain();
         else if (i < RANDOM_REQUESTS - CALM_TAIL && !(i >= 200 && i < 240)
                  && $urandom_range(0, 2) == 0)
            sender_gap($urandom_range(1, 10));
      end

      start <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      run_over <= 1'b1;
      @(posedge clock);
      @(negedge clock);
      if (mismatch_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      #3_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/i2d_pkg.sv
hdl/i2d_front.sv
hdl/i2d_back.sv
hdl/int64_to_decimal_ascii_top.sv
tb/i2d_checker.sv
tb/tb_int64_to_decimal_ascii_top.sv
